@@ rtl/snq_pkg.sv @@
// Shared constants, codes and types of the scale note quantizer.
`timescale 1ns / 1ps
`default_nettype none

package snq_pkg;

  // Notes that belong to the allowed set run from 0 to NOTE_COUNT-1.
  localparam int NOTE_COUNT = 128;
  localparam int LAST_NOTE  = NOTE_COUNT - 1;

  localparam int NOTE_W     = 7;
  localparam int NOTE_MAX   = (1 << NOTE_W) - 1;
  localparam int PC_COUNT   = 12;
  localparam int PC_W       = 4;
  localparam int SCALE_W    = 12;
  localparam int DEGREE_W   = 7;
  localparam int DEG_IDX_W  = $clog2(DEGREE_W);
  localparam int MODE_W     = 2;
  localparam int ROOT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Width that holds a note plus one octave of search distance.
  localparam int EXT_W      = $clog2(NOTE_COUNT + PC_COUNT);

  // Pitch class of the highest note in range.
  localparam int LAST_PC    = LAST_NOTE % PC_COUNT;

  // floor(n / 12) equals (n * 43) >> 9 for every 7-bit n.
  localparam int RECIP       = 43;
  localparam int RECIP_SHIFT = 9;
  localparam int RECIP_W     = NOTE_W + 6;

  localparam logic [SCALE_W-1:0] SCALE_RESET = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS    = 2'd0,
    MODE_NEAREST = 2'd1,
    MODE_UP      = 2'd2,
    MODE_DOWN    = 2'd3
  } snap_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOT   = 2'd0,
    REG_SCALE  = 2'd1,
    REG_DEGREE = 2'd2,
    REG_MODE   = 2'd3
  } cfg_reg_t;

  // Settings as the snapping logic needs them: the allowed pitch classes
  // in absolute terms (bit p is pitch class p, C = 0) and the snap mode.
  typedef struct packed {
    logic [SCALE_W-1:0] pc_mask;
    snap_mode_t         mode;
  } snq_cfg_t;

endpackage

`default_nettype wire

@@ rtl/snq_config.sv @@
// Configuration registers and the derived absolute pitch-class mask.
`timescale 1ns / 1ps
`default_nettype none

module snq_config
  import snq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire cfg_reg_t              wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output snq_cfg_t                   cfg
);

  logic [ROOT_W-1:0]   root_pitch;
  logic [SCALE_W-1:0]  scale_mask;
  logic [DEGREE_W-1:0] degree_mask;
  snap_mode_t          snap_mode;
  logic [SCALE_W-1:0]  pc_mask;
  logic [SCALE_W-1:0]  pc_mask_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_pitch  <= '0;
      scale_mask  <= SCALE_RESET;
      degree_mask <= '0;
      snap_mode   <= MODE_PASS;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ROOT:   root_pitch  <= wr_data[ROOT_W-1:0];
        REG_SCALE:  scale_mask  <= wr_data[SCALE_W-1:0];
        REG_DEGREE: degree_mask <= wr_data[DEGREE_W-1:0];
        REG_MODE:   snap_mode   <= snap_mode_t'(wr_data[MODE_W-1:0]);
      endcase
    end
  end

  // Degree k+1 is the k-th set bit of the scale mask. Each interval's rank
  // is counted on its own, so the bits are independent of one another.
  always_comb begin
    logic [SCALE_W-1:0]     act;
    logic [SCALE_W-1:0]     picked;
    logic [(1<<DEG_IDX_W)-1:0] deg_ext;
    logic [PC_W-1:0]        root_eff;
    logic [PC_W-1:0]        rank;
    logic [PC_W:0]          rot;
    picked  = '0;
    deg_ext = (1 << DEG_IDX_W)'(degree_mask);
    for (int i = 0; i < SCALE_W; i++) begin
      rank = PC_W'($countones(scale_mask & ((SCALE_W'(1) << i) - SCALE_W'(1))));
      picked[i] = scale_mask[i] && (rank < PC_W'(DEGREE_W)) && deg_ext[rank[DEG_IDX_W-1:0]];
    end
    if (degree_mask == '0 || picked == '0) begin
      act = scale_mask;
    end else begin
      act = picked;
    end
    // A root beyond B counts as C.
    root_eff = (root_pitch > ROOT_W'(PC_COUNT - 1)) ? '0 : root_pitch;
    for (int p = 0; p < PC_COUNT; p++) begin
      rot = (PC_W + 1)'(p + PC_COUNT) - (PC_W + 1)'(root_eff);
      if (rot >= (PC_W + 1)'(PC_COUNT)) begin
        rot = rot - (PC_W + 1)'(PC_COUNT);
      end
      pc_mask_next[p] = act[rot[PC_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_mask <= SCALE_RESET;
    end else begin
      pc_mask <= pc_mask_next;
    end
  end

  assign cfg.pc_mask = pc_mask;
  assign cfg.mode    = snap_mode;

endmodule

`default_nettype wire

@@ rtl/snq_snap.sv @@
// Snaps one note to the allowed pitch classes by a twelve-wide search.
`timescale 1ns / 1ps
`default_nettype none

module snq_snap
  import snq_pkg::*;
(
  input  wire logic [NOTE_W-1:0] note,
  input  wire snq_cfg_t          cfg,
  output logic [NOTE_W-1:0]      result
);

  // Distance from pitch class pc up to the first allowed class.
  function automatic logic [PC_W-1:0] dist_up(input logic [SCALE_W-1:0] mask,
                                              input logic [PC_W-1:0] pc);
    logic [PC_W-1:0] d;
    logic [PC_W:0]   idx;
    d = '0;
    for (int k = PC_COUNT - 1; k >= 0; k--) begin
      idx = (PC_W + 1)'(pc) + (PC_W + 1)'(k);
      if (idx >= (PC_W + 1)'(PC_COUNT)) begin
        idx = idx - (PC_W + 1)'(PC_COUNT);
      end
      if (mask[idx[PC_W-1:0]]) begin
        d = PC_W'(k);
      end
    end
    return d;
  endfunction

  // Distance from pitch class pc down to the first allowed class.
  function automatic logic [PC_W-1:0] dist_dn(input logic [SCALE_W-1:0] mask,
                                              input logic [PC_W-1:0] pc);
    logic [PC_W-1:0] d;
    logic [PC_W:0]   idx;
    d = '0;
    for (int k = PC_COUNT - 1; k >= 0; k--) begin
      idx = (PC_W + 1)'(pc) + (PC_W + 1)'(PC_COUNT - k);
      if (idx >= (PC_W + 1)'(PC_COUNT)) begin
        idx = idx - (PC_W + 1)'(PC_COUNT);
      end
      if (mask[idx[PC_W-1:0]]) begin
        d = PC_W'(k);
      end
    end
    return d;
  endfunction

  logic [RECIP_W-1:0] prod;
  logic [PC_W-1:0]    octave;
  logic [NOTE_W-1:0]  rem;
  logic [PC_W-1:0]    pc;
  logic [PC_W-1:0]    d_up;
  logic [PC_W-1:0]    d_dn;
  logic [PC_W-1:0]    d_high;
  logic [PC_W-1:0]    d_low;
  logic [EXT_W-1:0]   above;
  logic [NOTE_W-1:0]  below;
  logic [EXT_W-1:0]   highest;
  logic [EXT_W-1:0]   lowest;
  logic               has_above;
  logic               has_below;
  logic [EXT_W-1:0]   pick;

  always_comb begin
    prod   = RECIP_W'(note) * RECIP_W'(RECIP);
    octave = PC_W'(prod >> RECIP_SHIFT);
    rem    = note - NOTE_W'(octave) * NOTE_W'(PC_COUNT);
    if (rem >= NOTE_W'(PC_COUNT)) begin
      rem = rem - NOTE_W'(PC_COUNT);
    end
    pc = rem[PC_W-1:0];
  end

  assign d_up   = dist_up(cfg.pc_mask, pc);
  assign d_dn   = dist_dn(cfg.pc_mask, pc);
  assign d_high = dist_dn(cfg.pc_mask, PC_W'(LAST_PC));
  assign d_low  = dist_up(cfg.pc_mask, '0);

  assign above     = EXT_W'(note) + EXT_W'(d_up);
  assign has_above = (above <= EXT_W'(LAST_NOTE));
  assign has_below = (NOTE_W'(d_dn) <= note);
  assign below     = note - NOTE_W'(d_dn);
  assign highest   = EXT_W'(LAST_NOTE) - EXT_W'(d_high);
  assign lowest    = EXT_W'(d_low);

  always_comb begin
    pick = EXT_W'(note);
    if (cfg.pc_mask != '0) begin
      case (cfg.mode)
        MODE_PASS:    pick = EXT_W'(note);
        MODE_NEAREST: begin
          if (!has_below) begin
            pick = above;
          end else if (!has_above) begin
            pick = EXT_W'(below);
          end else if (d_dn <= d_up) begin
            pick = EXT_W'(below);
          end else begin
            pick = above;
          end
        end
        MODE_UP:      pick = has_above ? above : highest;
        MODE_DOWN:    pick = has_below ? EXT_W'(below) : lowest;
      endcase
    end
    if (pick > EXT_W'(NOTE_MAX)) begin
      result = NOTE_W'(NOTE_MAX);
    end else begin
      result = pick[NOTE_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/scale_note_quantizer_top.sv @@
// Top level of the scale note quantizer: handshake stages and submodules.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                   Payload
// note      note_valid / note_ready     note_in   (7 bits, MIDI note)
// result    result_valid / result_ready note_out  (7 bits, snapped note)
// config    cfg_valid / cfg_ready       cfg_index (2 bits), cfg_data (12 bits)
//
// One note beat is accepted every cycle unless both stages are full and
// the result is stalled; each note passes through an input register and
// a result register. The single-cycle rate is set by the twelve-wide
// pitch-class search between those two registers.
// Reset is synchronous and active high; it empties both stages and loads
// the register reset values (root C, full chromatic scale, pass through).
// A stalled result holds its stage; the input stage keeps taking a beat
// as long as either stage has room, so a full stall backs up in two beats.

module scale_note_quantizer_top
  import snq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  note_valid,
  output logic                       note_ready,
  input  wire logic [NOTE_W-1:0]     note_in,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic [NOTE_W-1:0]          note_out,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  snq_cfg_t          cfg;
  logic              s1_valid;
  logic [NOTE_W-1:0] s1_note;
  logic [NOTE_W-1:0] snap_note;
  logic              out_en;
  logic              s1_en;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;

  snq_config u_config (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_reg_t'(cfg_index)),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The result register loads when it is empty or its beat is being taken;
  // the input register loads when it is empty or moves forward.
  assign out_en     = !result_valid || result_ready;
  assign s1_en      = !s1_valid || out_en;
  assign note_ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= note_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && note_valid) begin
      s1_note <= note_in;
    end
  end

  snq_snap u_snap (
    .note   (s1_note),
    .cfg    (cfg),
    .result (snap_note)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_en) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid) begin
      note_out <= snap_note;
    end
  end

  // In pass-through mode a note moves to the result unchanged.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_en && cfg.mode == MODE_PASS |=> note_out == $past(s1_note))
    else $error("pass-through mode altered the note");

  // With no allowed pitch class every note passes through.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_en && cfg.pc_mask == '0 |=> note_out == $past(s1_note))
    else $error("empty scale altered the note");

  // The input side only stalls when both stages hold a beat and the
  // result is not being taken.
  assert property (@(posedge clk) disable iff (rst)
    !note_ready |-> s1_valid && result_valid && !result_ready)
    else $error("input stalled while a stage had room");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the scale note quantizer top level.
`timescale 1ns / 1ps

module testbench;
  import snq_pkg::*;

  // Interval masks used by the directed tests, with the root as bit 0.
  localparam logic [SCALE_W-1:0] MAJOR_SCALE = 12'hAB5;
  localparam logic [SCALE_W-1:0] TRIAD_SCALE = 12'h091;
  localparam logic [SCALE_W-1:0] ROOT_ONLY   = 12'h001;

  // Spare cycles waited after the last result.
  localparam int PIPE_DEPTH  = 4;
  localparam int DRAIN_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  note_valid = 1'b0;
  logic                  note_ready;
  logic [NOTE_W-1:0]     note_in = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic [NOTE_W-1:0]     note_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // The bench keeps its own copy of the registers, updated on each accepted
  // configuration beat, so the prediction always matches what the block holds.
  logic [ROOT_W-1:0]   set_root   = '0;
  logic [SCALE_W-1:0]  set_scale  = SCALE_RESET;
  logic [DEGREE_W-1:0] set_degree = '0;
  snap_mode_t          set_mode   = MODE_PASS;

  // Snapped notes still owed by the block, oldest first.
  logic [NOTE_W-1:0] expected_notes[$];
  logic [NOTE_W-1:0] owed_note;
  int                mismatch_count = 0;

  // Random gaps on the note side and random stalls on the result side.
  // Both are switched off for the closing part of the run.
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;

  scale_note_quantizer_top DUT (
    .clk          (clk),
    .rst          (rst),
    .note_valid   (note_valid),
    .note_ready   (note_ready),
    .note_in      (note_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .note_out     (note_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Predicts the snapped note from the bench's copy of the registers.
  // The degree mask picks scale degrees in order of the set bits of the
  // scale mask; if it picks none, the whole scale is active. The search then
  // walks every note in range and keeps the nearest allowed one on each side.
  function automatic logic [NOTE_W-1:0] snap_note(input logic [NOTE_W-1:0] note);
    logic [SCALE_W-1:0] active;
    int rank;
    int root;
    int pc;
    int below, above, lowest, highest;
    bit has_below, has_above, any;
    int result;
    active = '0;
    rank = 0;
    below = 0;
    above = 0;
    lowest = 0;
    highest = 0;
    has_below = 1'b0;
    has_above = 1'b0;
    any = 1'b0;
    if (set_degree == '0) begin
      active = set_scale;
    end else begin
      for (int i = 0; i < PC_COUNT; i++) begin
        if (set_scale[i]) begin
          if (rank < DEGREE_W && set_degree[rank]) active[i] = 1'b1;
          rank++;
        end
      end
      if (active == '0) active = set_scale;
    end
    // A root past B falls back to C.
    root = (set_root > 11) ? 0 : int'(set_root);
    result = int'(note);
    if (set_mode != MODE_PASS && active != '0) begin
      for (int n = 0; n < NOTE_COUNT; n++) begin
        pc = (n + PC_COUNT - root) % PC_COUNT;
        if (active[pc]) begin
          if (!any) begin
            lowest = n;
            any = 1'b1;
          end
          highest = n;
          if (n <= note) begin
            below = n;
            has_below = 1'b1;
          end
          if (n >= note && !has_above) begin
            above = n;
            has_above = 1'b1;
          end
        end
      end
      if (any) begin
        case (set_mode)
          MODE_NEAREST: begin
            if (!has_below) result = above;
            else if (!has_above) result = below;
            else result = ((note - below) <= (above - note)) ? below : above;
          end
          MODE_UP: begin
            result = has_above ? above : highest;
          end
          default: begin
            result = has_below ? below : lowest;
          end
        endcase
      end
    end
    if (result > NOTE_MAX) result = NOTE_MAX;
    return result[NOTE_W-1:0];
  endfunction

  // Result side: ready drops in random bursts while stalls are on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Every result beat is matched against the oldest owed note.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_notes.size() == 0) begin
        mismatch_count++;
        $error("result beat with nothing owed: note_out %0d", note_out);
      end else begin
        owed_note = expected_notes.pop_front();
        if (note_out !== owed_note) begin
          mismatch_count++;
          $error("note_out: expected %0d, actual %0d", owed_note, note_out);
        end
      end
    end
  end

  // Offers one note beat, after a random gap if gaps are on, and returns at
  // the edge where it is taken. Valid is left high so that back-to-back beats
  // never see valid drop and rise within one step.
  task automatic send_note(input logic [NOTE_W-1:0] note);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      note_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    note_valid <= 1'b1;
    note_in <= note;
    do @(posedge clk); while (!note_ready);
    expected_notes.push_back(snap_note(note));
  endtask

  // Brings the block to rest: no note offered, nothing owed, and then a spare
  // wait so the pipeline has surely emptied.
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    note_valid <= 1'b0;
    while (expected_notes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_notes.size() != 0) begin
      mismatch_count++;
      $error("%0d results never arrived", expected_notes.size());
      expected_notes.delete();
    end
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // One configuration beat. Bits above a register's width carry random data,
  // since the block keeps only the low bits.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROOT:   set_root = value[ROOT_W-1:0];
      REG_SCALE:  set_scale = value[SCALE_W-1:0];
      REG_DEGREE: set_degree = value[DEGREE_W-1:0];
      default:    set_mode = snap_mode_t'(value[MODE_W-1:0]);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Loads all four registers once the block is at rest.
  task automatic configure(input logic [ROOT_W-1:0] root, input logic [SCALE_W-1:0] scale,
                           input logic [DEGREE_W-1:0] degree, input snap_mode_t mode);
    logic [CFG_DATA_W-1:0] word;
    settle();
    word = CFG_DATA_W'($urandom);
    word[ROOT_W-1:0] = root;
    write_reg(REG_ROOT, word);
    write_reg(REG_SCALE, scale);
    word = CFG_DATA_W'($urandom);
    word[DEGREE_W-1:0] = degree;
    write_reg(REG_DEGREE, word);
    word = CFG_DATA_W'($urandom);
    word[MODE_W-1:0] = mode;
    write_reg(REG_MODE, word);
  endtask

  // Straight after reset the block must pass notes through unchanged.
  task automatic test_reset_values();
    send_note(0);
    send_note(NOTE_W'(NOTE_MAX));
  endtask

  // Pass-through mode ignores even a sparse scale.
  task automatic test_pass_through();
    configure(4'd3, ROOT_ONLY, 7'd0, MODE_PASS);
    send_note(0);
    send_note(64);
  endtask

  // Nearest mode in C major; a note halfway between two allowed notes goes down.
  task automatic test_nearest_ties();
    configure(4'd0, MAJOR_SCALE, 7'd0, MODE_NEAREST);
    send_note(1);
    send_note(6);
    send_note(0);
    send_note(NOTE_W'(NOTE_MAX));
  endtask

  // Only F is allowed, so notes above the top F clamp back down to it.
  task automatic test_up_clamp();
    configure(4'd5, ROOT_ONLY, 7'd0, MODE_UP);
    send_note(126);
    send_note(NOTE_W'(NOTE_MAX));
    send_note(0);
  endtask

  // Only B is allowed, so notes below the lowest B clamp up to it.
  task automatic test_down_clamp();
    configure(4'd11, ROOT_ONLY, 7'd0, MODE_DOWN);
    send_note(0);
    send_note(5);
    send_note(NOTE_W'(NOTE_MAX));
  endtask

  // Roots past B behave as C.
  task automatic test_root_out_of_range();
    configure(4'd12, ROOT_ONLY, 7'd0, MODE_NEAREST);
    send_note(7);
    configure(4'd15, TRIAD_SCALE, 7'd0, MODE_DOWN);
    send_note(3);
  endtask

  // Degree selection: first C and E of C major, then degrees past the end of
  // a three-note scale, which leave the whole scale active.
  task automatic test_degree_mask();
    configure(4'd0, MAJOR_SCALE, 7'b0000101, MODE_NEAREST);
    send_note(2);
    send_note(3);
    configure(4'd0, TRIAD_SCALE, 7'b1111000, MODE_NEAREST);
    send_note(2);
    send_note(6);
  endtask

  // With no interval in the scale every mode passes the note through.
  task automatic test_empty_scale();
    configure(4'd7, 12'd0, 7'd127, MODE_NEAREST);
    send_note(9);
    configure(4'd7, 12'd0, 7'd0, MODE_UP);
    send_note(NOTE_W'(NOTE_MAX));
    configure(4'd7, 12'd0, 7'd1, MODE_DOWN);
    send_note(0);
  endtask

  // Random phases: each loads a fresh setting and then plays random notes.
  // The first phases hold the extreme settings; the last ones run with no
  // gaps and no stalls so the block is kept at full rate.
  task automatic test_random_phases();
    logic [SCALE_W-1:0] scale;
    logic [DEGREE_W-1:0] degree;
    logic [NOTE_W-1:0] note;
    for (int phase = 0; phase < 38; phase++) begin
      if (phase == 34) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      case ($urandom_range(0, 5))
        0: scale = '0;
        1: scale = SCALE_RESET;
        2: scale = 12'd1 << $urandom_range(0, 11);
        default: scale = SCALE_W'($urandom);
      endcase
      degree = ($urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom);
      if (phase == 0) begin
        configure(4'd0, SCALE_RESET, 7'd0, MODE_PASS);
      end else if (phase == 1) begin
        configure(4'd15, '0, 7'd127, MODE_DOWN);
      end else if (phase == 2) begin
        configure(4'd11, SCALE_RESET, 7'd127, MODE_UP);
      end else begin
        configure(4'($urandom), scale, degree, snap_mode_t'($urandom_range(0, 3)));
      end
      for (int k = 0; k < 50; k++) begin
        case ($urandom_range(0, 9))
          0: note = '0;
          1: note = NOTE_W'(NOTE_MAX);
          default: note = NOTE_W'($urandom);
        endcase
        send_note(note);
      end
    end
  endtask

  initial begin
    // Synchronous reset is held first and released on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_pass_through();
    test_nearest_ties();
    test_up_clamp();
    test_down_clamp();
    test_root_out_of_range();
    test_degree_mask();
    test_empty_scale();
    test_random_phases();

    // Wait for every owed result, then a spare wait for anything stray.
    settle();
    repeat (PIPE_DEPTH * 2) @(posedge clk);
    if (expected_notes.size() != 0) begin
      mismatch_count++;
      $error("%0d results still owed at the end", expected_notes.size());
    end
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
